// ===== hw/rtl/magic_packet_detector_assert.svh =====
// Assertion macros shared by the magic packet detector RTL.
`ifndef MAGIC_PACKET_DETECTOR_ASSERT_SVH
`define MAGIC_PACKET_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("magic packet detector: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("magic packet detector: next-cycle check failed");

`endif

// ===== hw/rtl/mpd_pkg.sv =====
// Shared constants and types of the magic packet detector.
package mpd_pkg;

    localparam int BYTE_W      = 8;
    localparam int SYNC_BYTES  = 6;
    localparam int MAC_REPEATS = 16;
    localparam int MAC_BYTES   = 6;
    localparam int MAC_W       = BYTE_W * MAC_BYTES;
    localparam int PATTERN_LEN = SYNC_BYTES + MAC_REPEATS * MAC_BYTES;
    localparam int WINDOW_LEN  = PATTERN_LEN - 1;
    localparam int COUNT_W     = 16;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [BYTE_W-1:0]  SYNC_VALUE   = 8'hFF;
    localparam logic [COUNT_W-1:0] SCAN_RESET   = 16'd1518;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [COUNT_W-1:0] WINDOW_COUNT = COUNT_W'(WINDOW_LEN);
    localparam logic [MAC_W-1:0]   MAC_ONES     = '1;
    localparam logic [MAC_W-1:0]   MAC_ZEROS    = '0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_STATION_MAC = 1'b0,
        CFG_SCAN_LIMIT  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [MAC_W-1:0]   station_mac;
        logic [COUNT_W-1:0] scan_limit;
    } t_cfg;

    typedef struct packed {
        logic              fire;
        logic              last;
        logic [BYTE_W-1:0] data;
    } t_step;

endpackage

// ===== hw/rtl/mpd_pattern.sv =====
// Parallel equality tree that checks the window plus the current byte for the pattern.
module mpd_pattern (
    input  logic [mpd_pkg::BYTE_W-1:0] i_window [mpd_pkg::WINDOW_LEN],
    input  logic [mpd_pkg::BYTE_W-1:0] i_data_byte,
    input  logic [mpd_pkg::MAC_W-1:0]  i_station_mac,
    output logic                       o_hit
);

    logic [mpd_pkg::BYTE_W-1:0]      w_seq [mpd_pkg::PATTERN_LEN];
    logic [mpd_pkg::PATTERN_LEN-1:0] w_eq;

    genvar gi;

    for (gi = 0; gi < mpd_pkg::WINDOW_LEN; gi++) begin : g_seq
        assign w_seq[gi] = i_window[gi];
    end
    assign w_seq[mpd_pkg::WINDOW_LEN] = i_data_byte;

    for (gi = 0; gi < mpd_pkg::SYNC_BYTES; gi++) begin : g_sync
        assign w_eq[gi] = (w_seq[gi] == mpd_pkg::SYNC_VALUE);
    end

    // Each repeat of the address starts with the octet held in the top byte.
    for (gi = mpd_pkg::SYNC_BYTES; gi < mpd_pkg::PATTERN_LEN; gi++) begin : g_mac
        localparam int OCT = (gi - mpd_pkg::SYNC_BYTES) % mpd_pkg::MAC_BYTES;
        assign w_eq[gi] = (w_seq[gi] ==
            i_station_mac[mpd_pkg::BYTE_W*(mpd_pkg::MAC_BYTES-1-OCT) +: mpd_pkg::BYTE_W]);
    end

    assign o_hit = &w_eq;

endmodule

// ===== hw/rtl/mpd_scan.sv =====
// Frame state: byte window, saturating position count and sticky found flag.
module mpd_scan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mpd_pkg::t_step i_step,
    input  mpd_pkg::t_cfg  i_cfg,
    output logic           o_found
);

    logic [mpd_pkg::BYTE_W-1:0]  r_window [mpd_pkg::WINDOW_LEN];
    logic [mpd_pkg::COUNT_W-1:0] r_count;
    logic [mpd_pkg::COUNT_W-1:0] n_count;
    logic                        r_found;
    logic                        n_found;
    logic                        w_pat_hit;
    logic                        w_hit;

    mpd_pattern u_pattern (
        .i_window      (r_window),
        .i_data_byte   (i_step.data),
        .i_station_mac (i_cfg.station_mac),
        .o_hit         (w_pat_hit)
    );

    // Once the count reaches the window length, every window byte belongs to
    // this frame, so the window needs no clearing between frames.
    assign w_hit = (r_count >= mpd_pkg::WINDOW_COUNT) && (r_count < i_cfg.scan_limit)
                   && w_pat_hit;
    assign o_found = r_found | w_hit;

    always_comb begin
        n_count = r_count;
        n_found = r_found;
        if (i_step.fire) begin
            if (i_step.last) begin
                n_count = '0;
                n_found = 1'b0;
            end else begin
                n_found = o_found;
                if (r_count != mpd_pkg::COUNT_MAX) begin
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_found <= 1'b0;
        end else begin
            r_count <= n_count;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.fire) begin
            for (int i = 0; i < mpd_pkg::WINDOW_LEN - 1; i++) begin
                r_window[i] <= r_window[i+1];
            end
            r_window[mpd_pkg::WINDOW_LEN-1] <= i_step.data;
        end
    end

endmodule

// ===== hw/rtl/magic_packet_detector.sv =====
// Top level of the magic packet detector: handshakes, configuration and result register.
//
// Frame bytes enter on the input channel (i_in_valid / o_in_ready), one byte per
// transfer, with i_last_byte set on the final byte of the frame. Each frame gives
// exactly one result transfer on the output channel (o_out_valid / i_out_ready),
// carrying o_match, after its final byte; other bytes give no result.
// A byte is registered on its transfer and scanned from the input register; a final
// byte may wait there, and the frame's result is registered when that byte is scanned.
// Throughput is one byte per cycle unless a final byte waits; the clock period is set by
// the equality tree over the 101-byte window, the current byte and the position compare.
// Registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata at any edge:
// index 0 is the station MAC, index 1 the scan limit (reset 1518).
// When the receiver stalls, non-final bytes keep flowing; a final byte waits in
// the input register until the previous result is taken, and o_in_ready drops.
// Synchronous reset clears the count, found flag, both channel valids and the registers.
`include "magic_packet_detector_assert.svh"

module magic_packet_detector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [mpd_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                             i_last_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_match,
    input  logic                             i_cfg_we,
    input  logic [mpd_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [mpd_pkg::MAC_W-1:0]        i_cfg_wdata
);

    mpd_pkg::t_cfg               r_cfg;
    logic                        r_in_valid;
    logic [mpd_pkg::BYTE_W-1:0]  r_in_byte;
    logic                        r_in_last;
    logic                        r_out_valid;
    logic                        r_out_match;
    logic                        w_out_free;
    logic                        w_fire;
    logic                        w_usable;
    logic                        w_found;
    mpd_pkg::t_step              w_step;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && (!r_in_last || w_out_free);
    assign o_in_ready = !r_in_valid || w_fire;
    assign w_usable   = (r_cfg.station_mac != mpd_pkg::MAC_ONES) &&
                        (r_cfg.station_mac != mpd_pkg::MAC_ZEROS);

    assign w_step.fire = w_fire;
    assign w_step.last = r_in_last;
    assign w_step.data = r_in_byte;

    mpd_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_cfg   (r_cfg),
        .o_found (w_found)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.station_mac <= '0;
            r_cfg.scan_limit  <= mpd_pkg::SCAN_RESET;
        end else if (i_cfg_we) begin
            unique case (mpd_pkg::t_cfg_reg'(i_cfg_addr))
                mpd_pkg::CFG_STATION_MAC: r_cfg.station_mac <= i_cfg_wdata;
                mpd_pkg::CFG_SCAN_LIMIT:  r_cfg.scan_limit  <= i_cfg_wdata[mpd_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_last) begin
            r_out_match <= w_found && w_usable;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_match     = r_out_match;

    `MPD_ASSERT_NOW(a_no_result_overwrite, i_clk, i_rst_n, r_out_valid && !i_out_ready, !(w_fire && r_in_last))
    `MPD_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, w_fire && r_in_last, o_out_valid)
    `MPD_ASSERT_NEXT(a_bad_mac_no_match, i_clk, i_rst_n, w_fire && r_in_last && !w_usable, !o_match)
    `MPD_ASSERT_NOW(a_ready_when_free, i_clk, i_rst_n, r_in_valid && o_in_ready, w_fire)

endmodule
